>>> rtl/pcct_pkg.sv
// shared constants, codes and widths for the pointer cursor click tracker
package pcct_pkg;

   // fixed field widths
   localparam int MoveW   = 9;
   localparam int BtnW    = 3;
   localparam int TimeW   = 32;
   localparam int PosW    = 12;
   localparam int EventW  = 3;
   localparam int CountW  = 16;
   localparam int SizeW   = 13;
   localparam int TmoW    = 16;
   localparam int CsrIdxW = 2;
   localparam int CsrDataW = 16;

   // parameter defaults
   localparam int COORD_BITS_DEF = 12;
   localparam int TIME_BITS_DEF  = 32;

   // register reset values
   localparam logic [SizeW-1:0] SCREEN_WIDTH_RST  = 13'd1024;
   localparam logic [SizeW-1:0] SCREEN_HEIGHT_RST = 13'd768;
   localparam logic [TmoW-1:0]  CLICK_TIMEOUT_RST = 16'd500;

   // register indexes
   localparam logic [CsrIdxW-1:0] CSR_SCREEN_WIDTH  = 2'd0;
   localparam logic [CsrIdxW-1:0] CSR_SCREEN_HEIGHT = 2'd1;
   localparam logic [CsrIdxW-1:0] CSR_CLICK_TIMEOUT = 2'd2;

   // thresholds
   localparam int NOISE_LIMIT     = 10;
   localparam int CHAIN_RADIUS_SQ = 5;

   // button masks
   localparam logic [BtnW-1:0] BTN_LEFT   = 3'b001;
   localparam logic [BtnW-1:0] BTN_MIDDLE = 3'b010;
   localparam logic [BtnW-1:0] BTN_RIGHT  = 3'b100;

   // button event codes
   localparam logic [EventW-1:0] EV_NONE           = 3'd0;
   localparam logic [EventW-1:0] EV_LEFT_PRESS     = 3'd1;
   localparam logic [EventW-1:0] EV_LEFT_RELEASE   = 3'd2;
   localparam logic [EventW-1:0] EV_RIGHT_PRESS    = 3'd3;
   localparam logic [EventW-1:0] EV_RIGHT_RELEASE  = 3'd4;
   localparam logic [EventW-1:0] EV_MIDDLE_PRESS   = 3'd5;
   localparam logic [EventW-1:0] EV_MIDDLE_RELEASE = 3'd6;

   localparam logic [CountW-1:0] COUNT_MAX = 16'hFFFF;

endpackage

>>> rtl/pcct_req_if.sv
// mouse report channel: valid/ready with the report fields
interface pcct_req_if;
   logic                           valid;
   logic                           ready;
   logic signed [pcct_pkg::MoveW-1:0] move_x;
   logic signed [pcct_pkg::MoveW-1:0] move_y;
   logic [pcct_pkg::BtnW-1:0]      button_bits;
   logic [pcct_pkg::TimeW-1:0]     time_ms;

   modport source (output valid, output move_x, output move_y, output button_bits,
                   output time_ms, input ready);
   modport sink   (input valid, input move_x, input move_y, input button_bits,
                   input time_ms, output ready);
endinterface

>>> rtl/pcct_rsp_if.sv
// tracker result channel: valid/ready with cursor and click fields
interface pcct_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [pcct_pkg::PosW-1:0]    pos_x;
   logic [pcct_pkg::PosW-1:0]    pos_y;
   logic                         move_applied;
   logic [pcct_pkg::EventW-1:0]  button_event;
   logic                         fresh_press;
   logic [pcct_pkg::CountW-1:0]  chain_count;

   modport source (output valid, output pos_x, output pos_y, output move_applied,
                   output button_event, output fresh_press, output chain_count,
                   input ready);
   modport sink   (input valid, input pos_x, input pos_y, input move_applied,
                   input button_event, input fresh_press, input chain_count,
                   output ready);
endinterface

>>> rtl/pointer_cursor_click_tracker_core.sv
// pointer cursor click tracker: cursor clamp, button events and click chains
//
// req_bus carries one mouse report per beat: signed move, held buttons and
// the current time in milliseconds. rsp_bus returns exactly one beat per
// report: cursor position, whether the move was applied, the button event,
// a fresh-press flag and the click chain count.
// the csr_ port writes screen width, screen height and click timeout; each
// write takes effect at the clock edge where csr_we is high.
// a report beat is captured into an input register, then all of its work is
// done in logic into the result register, so rsp valid rises once the beat
// has passed both registers; throughput is one report per cycle while
// rsp_bus does not stall. the cursor and chain state update in the cycle
// the result register loads, so the next report sees them without a bubble.
// when rsp_bus stalls, the result register holds and the input register
// takes one more report; after that req_bus.ready drops until a beat leaves.
// reset (synchronous) empties both registers, restores the csr defaults,
// centers the cursor on the default screen and clears the click chain.
module pointer_cursor_click_tracker_core #(
   parameter int COORD_BITS = pcct_pkg::COORD_BITS_DEF,
   parameter int TIME_BITS  = pcct_pkg::TIME_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   pcct_req_if.sink                       req_bus,
   pcct_rsp_if.source                     rsp_bus,
   input  logic                           csr_we,
   input  logic [pcct_pkg::CsrIdxW-1:0]   csr_index,
   input  logic [pcct_pkg::CsrDataW-1:0]  csr_wdata
);

   localparam int SzW  = COORD_BITS + 1;
   localparam int SumW = COORD_BITS + 2;
   localparam int DifW = COORD_BITS + 1;
   localparam int DsqW = 2 * DifW + 1;
   localparam int RstSizeX = (pcct_pkg::SCREEN_WIDTH_RST > (1 << COORD_BITS)) ?
                             (1 << COORD_BITS) : pcct_pkg::SCREEN_WIDTH_RST;
   localparam int RstSizeY = (pcct_pkg::SCREEN_HEIGHT_RST > (1 << COORD_BITS)) ?
                             (1 << COORD_BITS) : pcct_pkg::SCREEN_HEIGHT_RST;
   localparam logic [COORD_BITS-1:0] CURSOR_X_RST = COORD_BITS'(RstSizeX / 2);
   localparam logic [COORD_BITS-1:0] CURSOR_Y_RST = COORD_BITS'(RstSizeY / 2);

   // zero reads as one, oversize reads as the full coordinate range
   function automatic logic [SzW-1:0] eff_size(input logic [pcct_pkg::SizeW-1:0] r);
      logic [SzW-1:0] s;
      if (r == '0) begin
         s = SzW'(1);
      end else if (32'(r) > (32'(1) << COORD_BITS)) begin
         s = SzW'(1) << COORD_BITS;
      end else begin
         s = SzW'(r);
      end
      return s;
   endfunction

   function automatic logic [COORD_BITS-1:0] clamp(input logic signed [SumW-1:0] v,
                                                   input logic [SzW-1:0] size);
      logic [COORD_BITS-1:0] c;
      if (v < 0) begin
         c = '0;
      end else if (v >= $signed({1'b0, size})) begin
         c = COORD_BITS'(size - SzW'(1));
      end else begin
         c = v[COORD_BITS-1:0];
      end
      return c;
   endfunction

   // configuration registers
   logic [pcct_pkg::SizeW-1:0] screen_width_ff, screen_height_ff;
   logic [pcct_pkg::TmoW-1:0]  click_timeout_ff;

   // tracker state
   logic [COORD_BITS-1:0]     cursor_x_ff, cursor_y_ff, cursor_x_in, cursor_y_in;
   logic [pcct_pkg::BtnW-1:0] prev_buttons_ff;
   logic [TIME_BITS-1:0]      chain_start_ff, chain_start_in;
   logic [pcct_pkg::CountW-1:0] chain_clicks_ff, chain_clicks_in;
   logic [COORD_BITS-1:0]     origin_x_ff, origin_y_ff, origin_x_in, origin_y_in;

   // input register
   logic                              in_valid_ff;
   logic signed [pcct_pkg::MoveW-1:0] in_move_x_ff, in_move_y_ff;
   logic [pcct_pkg::BtnW-1:0]         in_buttons_ff;
   logic [TIME_BITS-1:0]              in_time_ff;

   // result register
   logic                          rsp_valid_ff;
   logic [COORD_BITS-1:0]         rsp_pos_x_ff, rsp_pos_y_ff;
   logic                          rsp_applied_ff, rsp_fresh_ff;
   logic [pcct_pkg::EventW-1:0]   rsp_event_ff;
   logic [pcct_pkg::CountW-1:0]   rsp_count_ff;

   logic out_free, req_take, advance;

   assign out_free = !rsp_valid_ff || rsp_bus.ready;
   assign req_bus.ready = !in_valid_ff || out_free;
   assign req_take = req_bus.valid && req_bus.ready;
   assign advance = in_valid_ff && out_free;

   // per-report logic
   logic [SzW-1:0]               size_x, size_y;
   logic signed [18:0]           move_sq;
   logic [pcct_pkg::BtnW-1:0]    delta;
   logic                         move_nz, applied, fresh, timed_out, far, restart;
   logic [COORD_BITS-1:0]        cur1_x, cur1_y;
   logic signed [DifW-1:0]       ddx, ddy;
   logic [DsqW-1:0]              dist_sq;
   logic [TIME_BITS-1:0]         gap;
   logic [pcct_pkg::EventW-1:0]  ev;

   always_comb begin
      size_x  = eff_size(screen_width_ff);
      size_y  = eff_size(screen_height_ff);
      move_sq = 19'(in_move_x_ff * in_move_x_ff) + 19'(in_move_y_ff * in_move_y_ff);
      delta   = prev_buttons_ff ^ in_buttons_ff;
      move_nz = (in_move_x_ff != '0) || (in_move_y_ff != '0);
      applied = move_nz && !((move_sq < 19'(pcct_pkg::NOISE_LIMIT)) && (delta != '0));

      cur1_x = cursor_x_ff;
      cur1_y = cursor_y_ff;
      if (applied) begin
         cur1_x = clamp(SumW'($signed({1'b0, cursor_x_ff})) + SumW'(in_move_x_ff), size_x);
         cur1_y = clamp(SumW'($signed({1'b0, cursor_y_ff})) + SumW'(in_move_y_ff), size_y);
      end

      // click chain: distance is taken from the cursor after this move
      fresh     = (delta != '0) && (in_buttons_ff == delta);
      ddx       = $signed({1'b0, origin_x_ff}) - $signed({1'b0, cur1_x});
      ddy       = $signed({1'b0, origin_y_ff}) - $signed({1'b0, cur1_y});
      dist_sq   = DsqW'(ddx * ddx) + DsqW'(ddy * ddy);
      far       = dist_sq >= DsqW'(pcct_pkg::CHAIN_RADIUS_SQ);
      gap       = in_time_ff - chain_start_ff;
      timed_out = (in_time_ff > chain_start_ff) && (gap > TIME_BITS'(click_timeout_ff));
      restart   = timed_out || far;

      chain_start_in  = chain_start_ff;
      chain_clicks_in = chain_clicks_ff;
      origin_x_in     = origin_x_ff;
      origin_y_in     = origin_y_ff;
      if (fresh) begin
         chain_start_in = in_time_ff;
         if (restart) begin
            chain_clicks_in = pcct_pkg::CountW'(1);
            origin_x_in     = cur1_x;
            origin_y_in     = cur1_y;
         end else if (chain_clicks_ff != pcct_pkg::COUNT_MAX) begin
            chain_clicks_in = chain_clicks_ff + pcct_pkg::CountW'(1);
         end
      end

      // middle over right over left
      if ((delta & pcct_pkg::BTN_MIDDLE) != '0) begin
         ev = ((in_buttons_ff & pcct_pkg::BTN_MIDDLE) != '0) ?
              pcct_pkg::EV_MIDDLE_PRESS : pcct_pkg::EV_MIDDLE_RELEASE;
      end else if ((delta & pcct_pkg::BTN_RIGHT) != '0) begin
         ev = ((in_buttons_ff & pcct_pkg::BTN_RIGHT) != '0) ?
              pcct_pkg::EV_RIGHT_PRESS : pcct_pkg::EV_RIGHT_RELEASE;
      end else if ((delta & pcct_pkg::BTN_LEFT) != '0) begin
         ev = ((in_buttons_ff & pcct_pkg::BTN_LEFT) != '0) ?
              pcct_pkg::EV_LEFT_PRESS : pcct_pkg::EV_LEFT_RELEASE;
      end else begin
         ev = pcct_pkg::EV_NONE;
      end

      // left release pulls a cursor left outside a shrunk screen back in
      cursor_x_in = cur1_x;
      cursor_y_in = cur1_y;
      if (ev == pcct_pkg::EV_LEFT_RELEASE) begin
         cursor_x_in = clamp(SumW'($signed({1'b0, cur1_x})), size_x);
         cursor_y_in = clamp(SumW'($signed({1'b0, cur1_y})), size_y);
      end
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         screen_width_ff  <= pcct_pkg::SCREEN_WIDTH_RST;
         screen_height_ff <= pcct_pkg::SCREEN_HEIGHT_RST;
         click_timeout_ff <= pcct_pkg::CLICK_TIMEOUT_RST;
      end else if (csr_we) begin
         case (csr_index)
            pcct_pkg::CSR_SCREEN_WIDTH: begin
               screen_width_ff <= csr_wdata[pcct_pkg::SizeW-1:0];
            end
            pcct_pkg::CSR_SCREEN_HEIGHT: begin
               screen_height_ff <= csr_wdata[pcct_pkg::SizeW-1:0];
            end
            pcct_pkg::CSR_CLICK_TIMEOUT: begin
               click_timeout_ff <= csr_wdata[pcct_pkg::TmoW-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // state and valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         cursor_x_ff     <= CURSOR_X_RST;
         cursor_y_ff     <= CURSOR_Y_RST;
         prev_buttons_ff <= '0;
         chain_start_ff  <= '0;
         chain_clicks_ff <= '0;
         origin_x_ff     <= '0;
         origin_y_ff     <= '0;
      end else begin
         if (req_take) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (advance) begin
            cursor_x_ff     <= cursor_x_in;
            cursor_y_ff     <= cursor_y_in;
            prev_buttons_ff <= in_buttons_ff;
            chain_start_ff  <= chain_start_in;
            chain_clicks_ff <= chain_clicks_in;
            origin_x_ff     <= origin_x_in;
            origin_y_ff     <= origin_y_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_move_x_ff  <= req_bus.move_x;
         in_move_y_ff  <= req_bus.move_y;
         in_buttons_ff <= req_bus.button_bits;
         in_time_ff    <= TIME_BITS'(req_bus.time_ms);
      end
      if (advance) begin
         rsp_pos_x_ff   <= cursor_x_in;
         rsp_pos_y_ff   <= cursor_y_in;
         rsp_applied_ff <= applied;
         rsp_event_ff   <= ev;
         rsp_fresh_ff   <= fresh;
         rsp_count_ff   <= chain_clicks_in;
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.pos_x        = pcct_pkg::PosW'(rsp_pos_x_ff);
   assign rsp_bus.pos_y        = pcct_pkg::PosW'(rsp_pos_y_ff);
   assign rsp_bus.move_applied = rsp_applied_ff;
   assign rsp_bus.button_event = rsp_event_ff;
   assign rsp_bus.fresh_press  = rsp_fresh_ff;
   assign rsp_bus.chain_count  = rsp_count_ff;

`ifndef SYNTH
   // a fresh press always reports a press event
   a_fresh_is_press: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_fresh_ff |->
         (rsp_event_ff == pcct_pkg::EV_LEFT_PRESS ||
          rsp_event_ff == pcct_pkg::EV_RIGHT_PRESS ||
          rsp_event_ff == pcct_pkg::EV_MIDDLE_PRESS))
      else $error("fresh press without a press event");

   // a fresh press leaves a nonzero chain
   a_fresh_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_fresh_ff |-> rsp_count_ff != '0)
      else $error("fresh press with zero chain count");

   // the chain count only restarts at one or steps up by one
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && chain_clicks_ff != $past(chain_clicks_ff) |->
         (chain_clicks_ff == pcct_pkg::CountW'(1) ||
          chain_clicks_ff == pcct_pkg::CountW'($past(chain_clicks_ff) + 1'b1)))
      else $error("chain count jumped");

   // an item that moves on always lands in the result register
   a_advance_lands: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("result lost after advance");

   // state only changes when an item moves on
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && !$past(advance) |->
         $stable(cursor_x_ff) && $stable(cursor_y_ff) && $stable(chain_clicks_ff))
      else $error("state changed without an item");
`endif

endmodule

>>> tb/pcct_report_checker.sv
// watches the report and result channels, predicts each result and compares it
module pcct_report_checker (
   input  logic                            clock,
   input  logic                            reset,
   pcct_req_if                             req_mon,
   pcct_rsp_if                             rsp_mon,
   input  logic                            csr_we,
   input  logic [pcct_pkg::CsrIdxW-1:0]    csr_index,
   input  logic [pcct_pkg::CsrDataW-1:0]   csr_wdata,
   output int                              error_count,
   output int                              outstanding
);
   import pcct_pkg::*;

   typedef struct packed {
      logic [PosW-1:0]   pos_x;
      logic [PosW-1:0]   pos_y;
      logic              move_applied;
      logic [EventW-1:0] button_event;
      logic              fresh_press;
      logic [CountW-1:0] chain_count;
   } tracker_result_t;

   // shadow of the csr file
   logic [SizeW-1:0]  scr_w;
   logic [SizeW-1:0]  scr_h;
   logic [TmoW-1:0]   click_tmo;

   // shadow of the cursor and chain state
   int                cur_x;
   int                cur_y;
   int                origin_x;
   int                origin_y;
   logic [BtnW-1:0]   held;
   logic [TimeW-1:0]  chain_t0;
   logic [CountW-1:0] chain_n;

   tracker_result_t   expected_results[$];

   // zero counts as one, anything past the coordinate range as the full range
   function automatic int screen_span(logic [SizeW-1:0] size_val);
      int span;
      span = size_val;
      if (span < 1) span = 1;
      if (span > (1 << COORD_BITS_DEF)) span = 1 << COORD_BITS_DEF;
      return span;
   endfunction

   function automatic int clamp_to(int v, int span);
      if (v < 0) v = 0;
      if (v >= span) v = span - 1;
      return v;
   endfunction

   function automatic void shift_cursor(int dx, int dy);
      cur_x = clamp_to(cur_x + dx, screen_span(scr_w));
      cur_y = clamp_to(cur_y + dy, screen_span(scr_h));
   endfunction

   function automatic tracker_result_t track_report(int mx, int my, logic [BtnW-1:0] btn,
                                                    logic [TimeW-1:0] now);
      tracker_result_t res;
      logic [BtnW-1:0] delta;
      int              ddx;
      int              ddy;
      logic            timed_out;
      res   = '0;
      delta = held ^ btn;
      // tiny moves that come with a button change are jitter
      if ((mx != 0 || my != 0) && !((mx * mx + my * my < NOISE_LIMIT) && delta != 0)) begin
         shift_cursor(mx, my);
         res.move_applied = 1'b1;
      end
      if (delta != 0) begin
         if (btn == delta) begin
            ddx       = origin_x - cur_x;
            ddy       = origin_y - cur_y;
            timed_out = (now > chain_t0) && ((now - chain_t0) > click_tmo);
            res.fresh_press = 1'b1;
            if (timed_out || ddx * ddx + ddy * ddy >= CHAIN_RADIUS_SQ) begin
               chain_n  = 1;
               origin_x = cur_x;
               origin_y = cur_y;
            end else if (chain_n != COUNT_MAX) begin
               chain_n = chain_n + 1'b1;
            end
            chain_t0 = now;
         end
         // later tests win: middle over right over left
         if ((delta & BTN_LEFT) != 0)
            res.button_event = ((btn & BTN_LEFT) != 0) ? EV_LEFT_PRESS : EV_LEFT_RELEASE;
         if ((delta & BTN_RIGHT) != 0)
            res.button_event = ((btn & BTN_RIGHT) != 0) ? EV_RIGHT_PRESS : EV_RIGHT_RELEASE;
         if ((delta & BTN_MIDDLE) != 0)
            res.button_event = ((btn & BTN_MIDDLE) != 0) ? EV_MIDDLE_PRESS : EV_MIDDLE_RELEASE;
         // left release pulls a cursor left outside a shrunk screen back in
         if (res.button_event == EV_LEFT_RELEASE) shift_cursor(0, 0);
      end
      held = btn;
      res.pos_x       = cur_x[PosW-1:0];
      res.pos_y       = cur_y[PosW-1:0];
      res.chain_count = chain_n;
      return res;
   endfunction

   function automatic void check_field(string field, longint want, longint got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
         error_count++;
      end
   endfunction

   always @(posedge clock) begin
      tracker_result_t want;
      if (reset) begin
         scr_w     = SCREEN_WIDTH_RST;
         scr_h     = SCREEN_HEIGHT_RST;
         click_tmo = CLICK_TIMEOUT_RST;
         cur_x     = int'(SCREEN_WIDTH_RST) / 2;
         cur_y     = int'(SCREEN_HEIGHT_RST) / 2;
         origin_x  = 0;
         origin_y  = 0;
         held      = '0;
         chain_t0  = '0;
         chain_n   = '0;
         expected_results.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_SCREEN_WIDTH:  scr_w = csr_wdata[SizeW-1:0];
               CSR_SCREEN_HEIGHT: scr_h = csr_wdata[SizeW-1:0];
               CSR_CLICK_TIMEOUT: click_tmo = csr_wdata[TmoW-1:0];
               default: ;
            endcase
         end
         if (req_mon.valid && req_mon.ready)
            expected_results.push_back(track_report($signed(req_mon.move_x),
                                                    $signed(req_mon.move_y),
                                                    req_mon.button_bits, req_mon.time_ms));
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_results.size() == 0) begin
               $display("%0t: result beat with nothing expected, expected none, actual pos=(%0d,%0d) ev=%0d count=%0d",
                        $time, rsp_mon.pos_x, rsp_mon.pos_y, rsp_mon.button_event,
                        rsp_mon.chain_count);
               error_count++;
            end else begin
               want = expected_results.pop_front();
               check_field("pos_x", want.pos_x, rsp_mon.pos_x);
               check_field("pos_y", want.pos_y, rsp_mon.pos_y);
               check_field("move_applied", want.move_applied, rsp_mon.move_applied);
               check_field("button_event", want.button_event, rsp_mon.button_event);
               check_field("fresh_press", want.fresh_press, rsp_mon.fresh_press);
               check_field("chain_count", want.chain_count, rsp_mon.chain_count);
            end
         end
      end
      outstanding = expected_results.size();
   end

endmodule

>>> tb/tb_pointer_cursor_click_tracker_core.sv
// testbench top: clock, reset, report stimulus, result stalls and the verdict
module tb_pointer_cursor_click_tracker_core;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int HOLD_CYCLES = 400;

   logic                          clock = 1'b0;
   logic                          reset;
   logic                          csr_we;
   logic [pcct_pkg::CsrIdxW-1:0]  csr_index;
   logic [pcct_pkg::CsrDataW-1:0] csr_wdata;
   int                            error_count;
   int                            outstanding;

   bit                            quiet = 1'b0;
   bit                            hold_request = 1'b0;
   logic [pcct_pkg::BtnW-1:0]     held_bits = '0;
   logic [pcct_pkg::TimeW-1:0]    clock_ms = 32'd100;
   int unsigned                   cur_tmo = 500;
   int unsigned                   cycle_count = 0;

   pcct_req_if req_ch ();
   pcct_rsp_if rsp_ch ();

   pointer_cursor_click_tracker_core DUT (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_ch),
      .rsp_bus   (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   pcct_report_checker report_check (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_ch),
      .rsp_mon     (rsp_ch),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .error_count (error_count),
      .outstanding (outstanding)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // result side: random stalls, one long hold-off on request, none when quiet
   initial begin
      rsp_ch.ready = 1'b0;
      @(posedge clock);
      forever begin
         if (hold_request) begin
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_request = 1'b0;
         end else if (!quiet && $urandom_range(0, 3) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clock);
         end else begin
            rsp_ch.ready <= 1'b1;
            repeat (quiet ? 1 : $urandom_range(1, 24)) @(posedge clock);
         end
      end
   end

   task automatic send_report(input int mx, input int my,
                              input logic [pcct_pkg::BtnW-1:0] btn,
                              input logic [pcct_pkg::TimeW-1:0] stamp);
      req_ch.valid       <= 1'b1;
      req_ch.move_x      <= pcct_pkg::MoveW'(mx);
      req_ch.move_y      <= pcct_pkg::MoveW'(my);
      req_ch.button_bits <= btn;
      req_ch.time_ms     <= stamp;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      held_bits = btn;
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
   endtask

   // stop offering and let every expected beat come back
   task automatic settle();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic apply_screen(input int w, input int h, input int tmo);
      csr_we    <= 1'b1;
      csr_index <= pcct_pkg::CSR_SCREEN_WIDTH;
      csr_wdata <= pcct_pkg::CsrDataW'(w);
      @(posedge clock);
      csr_index <= pcct_pkg::CSR_SCREEN_HEIGHT;
      csr_wdata <= pcct_pkg::CsrDataW'(h);
      @(posedge clock);
      csr_index <= pcct_pkg::CSR_CLICK_TIMEOUT;
      csr_wdata <= pcct_pkg::CsrDataW'(tmo);
      @(posedge clock);
      csr_we  <= 1'b0;
      cur_tmo = unsigned'(tmo);
   endtask

   task automatic run_random_reports(input int count, input int hold_at);
      for (int n = 0; n < count; n++) begin
         int                         pick;
         int                         mx;
         int                         my;
         logic [pcct_pkg::BtnW-1:0]  btn;
         logic [pcct_pkg::TimeW-1:0] stamp;
         if (n == hold_at) hold_request = 1'b1;
         pick  = $urandom_range(0, 9);
         mx    = int'($urandom_range(0, 511)) - 256;
         my    = int'($urandom_range(0, 511)) - 256;
         btn   = held_bits;
         if (pick >= 2 && pick < 8) begin
            // click-style traffic: small moves, button edges, gaps near the timeout
            mx = int'($urandom_range(0, 6)) - 3;
            my = int'($urandom_range(0, 6)) - 3;
            clock_ms = clock_ms + $urandom_range(0, cur_tmo + cur_tmo / 2 + 2);
            if (pick < 5) btn = held_bits ^ (pcct_pkg::BTN_LEFT << $urandom_range(0, 2));
            else btn = (held_bits == '0) ? pcct_pkg::BtnW'($urandom_range(1, 7)) : 3'b000;
         end else if (pick >= 8 && $urandom_range(0, 1) == 0) begin
            mx = int'($urandom_range(0, 10)) - 5;
            my = int'($urandom_range(0, 10)) - 5;
         end
         stamp = clock_ms;
         if (pick < 2) begin
            btn   = pcct_pkg::BtnW'($urandom);
            stamp = $urandom;
            if (pick == 0) clock_ms = stamp;
         end
         send_report(mx, my, btn, stamp);
      end
   endtask

   initial begin
      logic [pcct_pkg::TimeW-1:0] stamp;
      reset              = 1'b1;
      csr_we             = 1'b0;
      csr_index          = pcct_pkg::CSR_SCREEN_WIDTH;
      csr_wdata          = '0;
      req_ch.valid       = 1'b0;
      req_ch.move_x      = '0;
      req_ch.move_y      = '0;
      req_ch.button_bits = '0;
      req_ch.time_ms     = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // default screen: moves, noise drop, event priority, chain rules
      stamp = 32'd1000;
      send_report(255, 255, 3'b000, stamp);
      send_report(-256, -256, 3'b000, stamp);
      send_report(1, 1, pcct_pkg::BTN_LEFT, stamp);
      send_report(0, 0, 3'b000, stamp + 100);
      send_report(0, 0, pcct_pkg::BTN_LEFT, stamp + 200);
      send_report(0, 0, pcct_pkg::BTN_LEFT | pcct_pkg::BTN_MIDDLE, stamp + 210);
      send_report(0, 0, pcct_pkg::BTN_LEFT | pcct_pkg::BTN_MIDDLE | pcct_pkg::BTN_RIGHT,
                  stamp + 220);
      send_report(0, 0, 3'b000, stamp + 230);
      send_report(0, 0, pcct_pkg::BTN_RIGHT, stamp + 2000);
      send_report(0, 0, 3'b000, stamp + 2010);
      send_report(1, 1, 3'b000, stamp + 2020);
      send_report(0, 0, pcct_pkg::BTN_LEFT | pcct_pkg::BTN_RIGHT, stamp + 2030);
      send_report(-3, -1, 3'b000, stamp + 2040);
      send_report(0, 0, pcct_pkg::BTN_LEFT, stamp + 2050);
      send_report(0, 0, 3'b000, stamp + 2060);
      send_report(0, 1, 3'b000, stamp + 2070);
      send_report(0, 0, pcct_pkg::BTN_LEFT, stamp + 2080);
      send_report(0, 0, 3'b000, stamp + 2090);
      // press stamped before the chain start never times out
      send_report(0, 0, pcct_pkg::BTN_LEFT, 32'd5);
      send_report(0, 0, 3'b000, 32'd6);
      repeat (2) send_report(-256, -256, 3'b000, 32'd7);
      repeat (4) send_report(255, 255, 3'b000, 32'd8);
      send_report(0, 0, pcct_pkg::BTN_MIDDLE, 32'hFFFF_FFFF);
      send_report(0, 0, 3'b000, 32'hFFFF_FFFF);

      // shrunk screen: cursor stays put until a move or a left release
      settle();
      apply_screen(100, 50, 0);
      stamp = 32'd777;
      send_report(0, 0, pcct_pkg::BTN_RIGHT, stamp);
      send_report(0, 0, 3'b000, stamp);
      send_report(0, 0, pcct_pkg::BTN_LEFT, stamp);
      send_report(0, 0, 3'b000, stamp);
      send_report(0, 0, pcct_pkg::BTN_LEFT, stamp + 1);
      send_report(0, 0, 3'b000, stamp + 1);

      // zero and oversized screen sizes
      settle();
      apply_screen(0, 8191, 1);
      send_report(5, 5, 3'b000, stamp);
      send_report(-7, 255, 3'b000, stamp);
      settle();
      apply_screen(4097, 1, 65535);
      send_report(255, -1, 3'b000, stamp);
      send_report(255, 255, 3'b000, stamp);

      // a long click chain: same spot, same time
      settle();
      apply_screen(4096, 4096, 65535);
      quiet = 1'b1;
      repeat (40) begin
         send_report(0, 0, pcct_pkg::BTN_LEFT, 32'd4000);
         send_report(0, 0, 3'b000, 32'd4000);
      end
      quiet = 1'b0;

      settle();
      apply_screen(1024, 768, 500);
      run_random_reports(400, 150);
      settle();
      apply_screen(0, 8191, 0);
      run_random_reports(400, -1);
      settle();
      apply_screen(1, 1, 65535);
      run_random_reports(400, -1);
      settle();
      apply_screen(4096, 4096, 1000);
      run_random_reports(400, -1);
      settle();
      apply_screen($urandom_range(0, 8191), $urandom_range(0, 8191),
                   $urandom_range(0, 65535));
      quiet = 1'b1;
      run_random_reports(400, -1);

      settle();
      repeat (8) @(posedge clock);
      if (error_count == 0 && outstanding == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

>>> sim.f
rtl/pcct_pkg.sv
rtl/pcct_req_if.sv
rtl/pcct_rsp_if.sv
rtl/pointer_cursor_click_tracker_core.sv
tb/pcct_report_checker.sv
tb/tb_pointer_cursor_click_tracker_core.sv
